// ----- rtl/rfc3339_timestamp_parser_top_macros.svh -----
// Assertion macros for the timestamp parser.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef RFC3339_TIMESTAMP_PARSER_TOP_MACROS_SVH
`define RFC3339_TIMESTAMP_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RTSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTSP_ASSERT_IMP(label, ante, cons, msg)
`define RTSP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/rtsp_pkg.sv -----
// Shared types and constants of the timestamp parser.
// No dependencies.
`default_nettype none
package rtsp_pkg;

    localparam int FRACTION_DIGITS_DEF = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TRUNC     = 4'd1,
        ST_DIGIT     = 4'd2,
        ST_SEP       = 4'd3,
        ST_MONTH     = 4'd4,
        ST_DAY       = 4'd5,
        ST_HOUR      = 4'd6,
        ST_MINUTE    = 4'd7,
        ST_SECOND    = 4'd8,
        ST_LEAP      = 4'd9,
        ST_FRACTION  = 4'd10,
        ST_OFFSET    = 4'd11,
        ST_OFF_RANGE = 4'd12,
        ST_RANGE     = 4'd13,
        ST_TRAILING  = 4'd14
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  position;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] fraction;
        logic        off_neg;
        logic [4:0]  off_hour;
        logic [5:0]  off_minute;
    } rec_t;

endpackage
`default_nettype wire

// ----- rtl/rtsp_front.sv -----
// Byte-wise grammar checker of the timestamp parser; pushes one record per text.
// Depends on rtsp_pkg.
`default_nettype none
module rtsp_front #(
    parameter int FRACTION_DIGITS = rtsp_pkg::FRACTION_DIGITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         q_full,
    output logic              q_push,
    output rtsp_pkg::rec_t    q_rec
);
    import rtsp_pkg::*;

    typedef enum logic [16:0] {
        PH_YEAR       = 17'h00001,
        PH_SEP_YM     = 17'h00002,
        PH_MONTH      = 17'h00004,
        PH_SEP_MD     = 17'h00008,
        PH_DAY        = 17'h00010,
        PH_T          = 17'h00020,
        PH_HOUR       = 17'h00040,
        PH_SEP_HM     = 17'h00080,
        PH_MINUTE     = 17'h00100,
        PH_SEP_MS     = 17'h00200,
        PH_SECOND     = 17'h00400,
        PH_AFTER_SEC  = 17'h00800,
        PH_FRACTION   = 17'h01000,
        PH_OFF_HOUR   = 17'h02000,
        PH_OFF_SEP    = 17'h04000,
        PH_OFF_MINUTE = 17'h08000,
        PH_DONE       = 17'h10000
    } phase_t;

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        begin
            case (m)
                4'd2: r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [29:0] pad_scale(input logic [3:0] n);
        logic [29:0] r;
        begin
            case (n)
                4'd0: r = 30'd1000000000;
                4'd1: r = 30'd100000000;
                4'd2: r = 30'd10000000;
                4'd3: r = 30'd1000000;
                4'd4: r = 30'd100000;
                4'd5: r = 30'd10000;
                4'd6: r = 30'd1000;
                4'd7: r = 30'd100;
                4'd8: r = 30'd10;
                default: r = 30'd1;
            endcase
            return r;
        end
    endfunction

    phase_t      phase_reg, phase_next;
    logic [5:0]  bi_reg, bi_next, fs_reg, fs_next, eidx_reg, eidx_next;
    logic [3:0]  dc_reg, dc_next;
    logic [13:0] acc_reg, acc_next, year_reg, year_next;
    logic [6:0]  pair_reg, pair_next, cent_reg, cent_next;
    logic        leap_reg, leap_next, neg_reg, neg_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next, hour_reg, hour_next, oh_reg, oh_next;
    logic [5:0]  min_reg, min_next, sec_reg, sec_next, om_reg, om_next;
    logic [29:0] frac_reg, frac_next;
    status_t     err_reg, err_next;

    logic        accept, isd;
    logic [3:0]  dig;
    logic [13:0] acc_v;
    logic [6:0]  pair_v;
    logic [29:0] frac_v, frac_pad;
    logic [3:0]  need;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign isd      = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign dig      = isd ? 4'(in_byte - 8'h30) : 4'd0;
    assign acc_v    = 14'(acc_reg * 14'd10 + {10'd0, dig});
    assign pair_v   = dc_reg[0] ? 7'(pair_reg * 7'd10 + {3'd0, dig}) : {3'd0, dig};
    assign frac_v   = 30'(frac_reg * 30'd10 + {26'd0, dig});
    assign frac_pad = 30'(frac_reg * pad_scale(dc_reg));
    assign need     = (phase_reg == PH_YEAR) ? 4'd4 : 4'd2;

    always_comb
    begin
        phase_next = phase_reg;  bi_next = bi_reg;      fs_next = fs_reg;
        dc_next = dc_reg;        acc_next = acc_reg;    pair_next = pair_reg;
        cent_next = cent_reg;    leap_next = leap_reg;  year_next = year_reg;
        month_next = month_reg;  day_next = day_reg;    hour_next = hour_reg;
        min_next = min_reg;      sec_next = sec_reg;    frac_next = frac_reg;
        neg_next = neg_reg;      oh_next = oh_reg;      om_next = om_reg;
        err_next = err_reg;      eidx_next = eidx_reg;
        q_push = 1'b0;
        q_rec = '0;

        if (accept && err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
                PH_OFF_HOUR, PH_OFF_MINUTE:
                begin
                    if (dc_reg == 4'd0)
                        fs_next = bi_reg;
                    if (!isd)
                    begin
                        err_next = ST_DIGIT;
                        eidx_next = bi_reg;
                    end
                    else
                    begin
                        acc_next = acc_v;
                        dc_next = dc_reg + 4'd1;
                        pair_next = pair_v;
                        if (phase_reg == PH_YEAR && dc_reg == 4'd1)
                            cent_next = pair_v;
                        if (dc_reg + 4'd1 >= need)
                        begin
                            acc_next = '0;
                            dc_next = '0;
                            case (phase_reg)
                                PH_YEAR:
                                begin
                                    year_next = acc_v;
                                    leap_next = (pair_v[1:0] == 2'd0)
                                        && (pair_v != 7'd0 || cent_reg[1:0] == 2'd0);
                                    phase_next = PH_SEP_YM;
                                end
                                PH_MONTH:
                                    if (acc_v < 14'd1 || acc_v > 14'd12)
                                    begin
                                        err_next = ST_MONTH; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        month_next = acc_v[3:0]; phase_next = PH_SEP_MD;
                                    end
                                PH_DAY:
                                    if (acc_v < 14'd1
                                        || acc_v > {9'd0, days_in_month(month_reg, leap_reg)})
                                    begin
                                        err_next = ST_DAY; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        day_next = acc_v[4:0]; phase_next = PH_T;
                                    end
                                PH_HOUR:
                                    if (acc_v > 14'd23)
                                    begin
                                        err_next = ST_HOUR; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        hour_next = acc_v[4:0]; phase_next = PH_SEP_HM;
                                    end
                                PH_MINUTE:
                                    if (acc_v > 14'd59)
                                    begin
                                        err_next = ST_MINUTE; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        min_next = acc_v[5:0]; phase_next = PH_SEP_MS;
                                    end
                                PH_SECOND:
                                    if (acc_v == 14'd60)
                                    begin
                                        err_next = ST_LEAP; eidx_next = fs_next;
                                    end
                                    else if (acc_v > 14'd60)
                                    begin
                                        err_next = ST_SECOND; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        sec_next = acc_v[5:0]; phase_next = PH_AFTER_SEC;
                                    end
                                PH_OFF_HOUR:
                                    if (acc_v > 14'd23)
                                    begin
                                        err_next = ST_OFF_RANGE; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        oh_next = acc_v[4:0]; phase_next = PH_OFF_SEP;
                                    end
                                default:
                                    if (acc_v > 14'd59)
                                    begin
                                        err_next = ST_OFF_RANGE; eidx_next = fs_next;
                                    end
                                    else
                                    begin
                                        om_next = acc_v[5:0]; phase_next = PH_DONE;
                                    end
                            endcase
                            if (err_next != ST_OK)
                            begin
                                acc_next = acc_v;
                                dc_next = dc_reg + 4'd1;
                            end
                        end
                    end
                end
                PH_SEP_YM, PH_SEP_MD:
                    if (in_byte != 8'h2D)
                    begin
                        err_next = ST_SEP; eidx_next = bi_reg;
                    end
                    else
                        phase_next = (phase_reg == PH_SEP_YM) ? PH_MONTH : PH_DAY;
                PH_T:
                    if (in_byte != 8'h54 && in_byte != 8'h74)
                    begin
                        err_next = ST_SEP; eidx_next = bi_reg;
                    end
                    else
                        phase_next = PH_HOUR;
                PH_SEP_HM, PH_SEP_MS, PH_OFF_SEP:
                    if (in_byte != 8'h3A)
                    begin
                        err_next = ST_SEP; eidx_next = bi_reg;
                    end
                    else if (phase_reg == PH_SEP_HM)
                        phase_next = PH_MINUTE;
                    else if (phase_reg == PH_SEP_MS)
                        phase_next = PH_SECOND;
                    else
                        phase_next = PH_OFF_MINUTE;
                PH_AFTER_SEC, PH_FRACTION:
                    if (phase_reg == PH_AFTER_SEC && in_byte == 8'h2E)
                    begin
                        phase_next = PH_FRACTION; dc_next = '0; frac_next = '0;
                    end
                    else if (phase_reg == PH_FRACTION && isd)
                    begin
                        if (dc_reg >= 4'(FRACTION_DIGITS))
                        begin
                            err_next = ST_FRACTION; eidx_next = bi_reg;
                        end
                        else
                        begin
                            frac_next = frac_v; dc_next = dc_reg + 4'd1;
                        end
                    end
                    else if (phase_reg == PH_FRACTION && dc_reg == 4'd0)
                    begin
                        err_next = ST_DIGIT; eidx_next = bi_reg;
                    end
                    else
                    begin
                        if (phase_reg == PH_FRACTION)
                            frac_next = frac_pad;
                        dc_next = '0;
                        acc_next = '0;
                        if (in_byte == 8'h5A || in_byte == 8'h7A)
                            phase_next = PH_DONE;
                        else if (in_byte == 8'h2B || in_byte == 8'h2D)
                        begin
                            neg_next = (in_byte == 8'h2D);
                            phase_next = PH_OFF_HOUR;
                        end
                        else
                        begin
                            err_next = ST_OFFSET; eidx_next = bi_reg;
                        end
                    end
                default:
                begin
                    err_next = ST_TRAILING; eidx_next = bi_reg;
                end
            endcase
            if (err_next == ST_OK && bi_reg < 6'd63)
                bi_next = bi_reg + 6'd1;
        end

        if (accept && in_last)
        begin
            q_push = 1'b1;
            q_rec.year = year_next;        q_rec.month = month_next;
            q_rec.day = day_next;          q_rec.hour = hour_next;
            q_rec.minute = min_next;       q_rec.second = sec_next;
            q_rec.fraction = frac_next;    q_rec.off_neg = neg_next;
            q_rec.off_hour = oh_next;      q_rec.off_minute = om_next;
            if (err_next != ST_OK)
            begin
                q_rec.status = err_next; q_rec.position = eidx_next;
            end
            else
            begin
                q_rec.status = (phase_next != PH_DONE) ? ST_TRUNC : ST_OK;
                q_rec.position = bi_next;
            end
            phase_next = PH_YEAR;  bi_next = '0;    fs_next = '0;    dc_next = '0;
            acc_next = '0;         pair_next = '0;  cent_next = '0;  leap_next = 1'b0;
            year_next = '0;        month_next = '0; day_next = '0;   hour_next = '0;
            min_next = '0;         sec_next = '0;   frac_next = '0;  neg_next = 1'b0;
            oh_next = '0;          om_next = '0;    err_next = ST_OK; eidx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_YEAR;  bi_reg <= '0;    fs_reg <= '0;    dc_reg <= '0;
            acc_reg <= '0;         pair_reg <= '0;  cent_reg <= '0;  leap_reg <= 1'b0;
            year_reg <= '0;        month_reg <= '0; day_reg <= '0;   hour_reg <= '0;
            min_reg <= '0;         sec_reg <= '0;   frac_reg <= '0;  neg_reg <= 1'b0;
            oh_reg <= '0;          om_reg <= '0;    err_reg <= ST_OK; eidx_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; bi_reg <= bi_next;       fs_reg <= fs_next;
            dc_reg <= dc_next;       acc_reg <= acc_next;     pair_reg <= pair_next;
            cent_reg <= cent_next;   leap_reg <= leap_next;   year_reg <= year_next;
            month_reg <= month_next; day_reg <= day_next;     hour_reg <= hour_next;
            min_reg <= min_next;     sec_reg <= sec_next;     frac_reg <= frac_next;
            neg_reg <= neg_next;     oh_reg <= oh_next;       om_reg <= om_next;
            err_reg <= err_next;     eidx_reg <= eidx_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rtsp_queue.sv -----
// Short record queue between the parser front and the conversion back end.
// Depends on rtsp_pkg.
`default_nettype none
module rtsp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  rtsp_pkg::rec_t       push_rec,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output rtsp_pkg::rec_t       head
);
    import rtsp_pkg::*;

    rec_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [QUEUE_AW:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rp_reg];

    always_comb
    begin
        wp_next = (push && !full) ? wp_reg + 1'b1 : wp_reg;
        rp_next = (pop && !empty) ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(pop && !empty);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wp_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rtsp_back.sv -----
// Conversion back end: calendar date and offset to nanoseconds, range check,
// and the output register. Depends on rtsp_pkg.
`default_nettype none
module rtsp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  rtsp_pkg::rec_t       q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [3:0]           out_status,
    output logic [5:0]           out_pos,
    output logic [63:0]          out_ns
);
    import rtsp_pkg::*;

    typedef enum logic [7:0] {
        B_IDLE = 8'h01,
        B_C1   = 8'h02,
        B_C2   = 8'h04,
        B_C3   = 8'h08,
        B_C4   = 8'h10,
        B_C5   = 8'h20,
        B_C6   = 8'h40,
        B_FIN  = 8'h80
    } bstate_t;

    function automatic logic [8:0] doy_base(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd1:  r = 9'd306;  4'd2:  r = 9'd337;  4'd3:  r = 9'd0;
                4'd4:  r = 9'd31;   4'd5:  r = 9'd61;   4'd6:  r = 9'd92;
                4'd7:  r = 9'd122;  4'd8:  r = 9'd153;  4'd9:  r = 9'd184;
                4'd10: r = 9'd214;  4'd11: r = 9'd245;  4'd12: r = 9'd275;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    bstate_t             st_reg;
    rec_t                cur_reg;
    logic [13:0]         yy_reg;
    logic [8:0]          doy_reg;
    logic [21:0]         m365_reg;
    logic [26:0]         m100_reg;
    logic [23:0]         m400_reg;
    logic [16:0]         tod_reg, off_reg;
    logic signed [23:0]  days_reg;
    logic signed [39:0]  sec_reg;
    logic                bad_reg;
    logic [49:0]         plo_reg;
    logic signed [50:0]  phi_reg;
    logic [3:0]          res_status_reg;
    logic [5:0]          res_pos_reg;
    logic [63:0]         res_ns_reg;
    logic                out_valid_reg;
    logic [3:0]          out_status_reg;
    logic [5:0]          out_pos_reg;
    logic [63:0]         out_ns_reg;

    logic [11:0]         q4;
    logic signed [24:0]  days_v;
    logic signed [39:0]  tod_s, off_s, base_s;
    logic                load_out;

    assign q4       = yy_reg[13:2];
    assign days_v   = $signed({3'd0, m365_reg}) + $signed({13'd0, q4})
                    - $signed({17'd0, m100_reg[26:19]}) + $signed({20'd0, m400_reg[23:19]})
                    + $signed({16'd0, doy_reg}) + $signed({20'd0, cur_reg.day})
                    - 25'sd865566;
    assign tod_s    = $signed({23'd0, tod_reg});
    assign off_s    = $signed({23'd0, off_reg});
    assign base_s   = days_reg * 40'sd86400 + tod_s;
    assign q_pop    = (st_reg == B_IDLE) && !q_empty;
    assign load_out = (st_reg == B_FIN) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_pos    = out_pos_reg;
    assign out_ns     = out_ns_reg;

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                cur_reg <= q_head;
                res_status_reg <= q_head.status;
                res_pos_reg <= q_head.position;
                res_ns_reg <= '0;
            end
            B_C1:
            begin
                yy_reg <= 14'(cur_reg.year + 14'd400 - {13'd0, (cur_reg.month <= 4'd2)});
                doy_reg <= doy_base(cur_reg.month);
            end
            B_C2:
            begin
                m365_reg <= 22'(yy_reg * 22'd365);
                m100_reg <= 27'(yy_reg * 27'd5243);
                m400_reg <= 24'(q4 * 24'd5243);
                tod_reg <= 17'(cur_reg.hour * 17'd3600 + cur_reg.minute * 17'd60
                             + {11'd0, cur_reg.second});
                off_reg <= 17'(cur_reg.off_hour * 17'd3600 + cur_reg.off_minute * 17'd60);
            end
            B_C3:
                days_reg <= days_v[23:0];
            B_C4:
                sec_reg <= cur_reg.off_neg ? base_s + off_s : base_s - off_s;
            B_C5:
            begin
                bad_reg <= (sec_reg > 40'sd9223372036)
                    || (sec_reg == 40'sd9223372036 && cur_reg.fraction > 30'd854775807)
                    || (sec_reg < -40'sd9223372037)
                    || (sec_reg == -40'sd9223372037 && cur_reg.fraction < 30'd145224192);
                plo_reg <= 50'(sec_reg[19:0] * 50'd1000000000);
                phi_reg <= $signed(sec_reg[39:20]) * 51'sd1000000000;
            end
            B_C6:
            begin
                res_status_reg <= bad_reg ? ST_RANGE : ST_OK;
                res_pos_reg <= bad_reg ? 6'd0 : cur_reg.position;
                res_ns_reg <= bad_reg ? 64'd0
                    : {phi_reg[43:0], 20'd0} + 64'(plo_reg) + {34'd0, cur_reg.fraction};
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg <= res_pos_reg;
            out_ns_reg <= res_ns_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (st_reg)
                B_IDLE:  if (!q_empty) st_reg <= (q_head.status == ST_OK) ? B_C1 : B_FIN;
                B_C1:    st_reg <= B_C2;
                B_C2:    st_reg <= B_C3;
                B_C3:    st_reg <= B_C4;
                B_C4:    st_reg <= B_C5;
                B_C5:    st_reg <= B_C6;
                B_C6:    st_reg <= B_FIN;
                B_FIN:   if (load_out) st_reg <= B_IDLE;
                default: st_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rfc3339_timestamp_parser_top.sv -----
// RFC 3339 timestamp parser, top level.
// Timestamp text enters one byte per beat on the slave stream; s_tdata holds the
// byte and s_tlast marks the final byte of a text. For each text one result beat
// leaves on the master stream with a status, a position and a nanosecond instant.
// A byte is checked in the cycle it is accepted, so bytes are taken one per cycle
// while the record queue (four entries) has room. On the last byte a record is
// queued; the conversion back end loads it when idle, runs six arithmetic steps
// and hands it to the output register in its final state; an erroneous text goes
// from idle straight to the final state. The result beat is valid once the final
// state loads the output register, which waits while a previous result is unread.
// Sustained rate is one byte per cycle for texts of eight bytes or more.
// When the receiver stalls, the result waits in the output register, the queue
// fills, and s_tready falls once it is full. Reset clears the parser state, empties
// the queue and drops any pending result. Depends on rtsp_pkg and the macro header.
`default_nettype none
`include "rfc3339_timestamp_parser_top_macros.svh"
module rfc3339_timestamp_parser_top #(
    parameter int FRACTION_DIGITS = rtsp_pkg::FRACTION_DIGITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // text_byte[7:0]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata    // status[3:0], position[9:4], instant_ns[73:10], zero
);
    import rtsp_pkg::*;

    logic        q_push, q_full, q_pop, q_empty;
    rec_t        push_rec, head_rec;
    logic [3:0]  status;
    logic [5:0]  position;
    logic [63:0] instant;

    rtsp_front #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_last(s_tlast), .q_full(q_full),
        .q_push(q_push), .q_rec(push_rec)
    );

    rtsp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_rec(push_rec), .full(q_full),
        .pop(q_pop), .empty(q_empty), .head(head_rec)
    );

    rtsp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(head_rec), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_status(status),
        .out_pos(position), .out_ns(instant)
    );

    assign m_tdata = {6'd0, instant, position, status};

    `RTSP_ASSERT_IMP(a_no_push_full, q_push, !q_full, "record pushed into full queue")
    `RTSP_ASSERT_IMP(a_err_zero, m_tvalid && status != ST_OK, instant == 64'd0,
        "failed text carries an instant")
    `RTSP_ASSERT_IMP(a_range_pos, m_tvalid && status == ST_RANGE, position == 6'd0,
        "out of range result with nonzero position")
    `RTSP_ASSERT_NXT(a_pop_queued, q_pop, !q_full, "queue still full after pop")

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for the RFC 3339 timestamp parser: streams timestamp texts byte by byte and
// checks each result beat against a behavioural predictor of the parser.
// Depends on rtsp_pkg and rfc3339_timestamp_parser_top.
module tb_top;
    import rtsp_pkg::*;

    typedef enum logic [4:0] {
        P_YEAR, P_SEP_YM, P_MONTH, P_SEP_MD, P_DAY, P_T, P_HOUR, P_SEP_HM,
        P_MINUTE, P_SEP_MS, P_SECOND, P_AFTER_SEC, P_FRACTION, P_OFF_HOUR,
        P_OFF_SEP, P_OFF_MINUTE, P_DONE
    } phase_t;

    typedef struct packed {
        status_t            status;
        logic [5:0]         position;
        logic signed [63:0] instant;
    } stamp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;

    rfc3339_timestamp_parser_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    logic [8:0] byte_queue[$];
    stamp_t     stamp_queue[$];
    int         fail_count = 0;
    int         result_count = 0;
    int         text_count = 0;
    int         cycle_count = 0;
    bit         quiet_stretch = 0;
    bit         hold_sender = 0;
    bit         in_taken = 0;

    // Parser model state.
    phase_t      ph;
    int unsigned idx, fstart, ndig, acc;
    int unsigned yr, mo, dy, hr, mi, se, frac, oneg, ohr, omi, ecode, eidx;

    function automatic void clear_parser();
        ph = P_YEAR; idx = 0; fstart = 0; ndig = 0; acc = 0;
        yr = 0; mo = 0; dy = 0; hr = 0; mi = 0; se = 0; frac = 0;
        oneg = 0; ohr = 0; omi = 0; ecode = 0; eidx = 0;
    endfunction

    function automatic void flag(status_t code, int unsigned pos);
        ecode = 32'(code);
        eidx = pos & 63;
    endfunction

    function automatic int unsigned month_length(int unsigned y, int unsigned m);
        int unsigned dim[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m < 1 || m > 12) return 0;
        if (m == 2 && leap) return 29;
        return dim[m - 1];
    endfunction

    function automatic longint epoch_days(int unsigned y, int unsigned m, int unsigned d);
        longint yy, era, yoe, mp, doy, doe;
        yy = longint'(y) + 400 - (m <= 2 ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp = (m > 2) ? longint'(m) - 3 : longint'(m) + 9;
        doy = (153 * mp + 2) / 5 + longint'(d) - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468 - 146097;
    endfunction

    function automatic void close_field();
        case (ph)
            P_YEAR:
            begin
                yr = acc;
                ph = P_SEP_YM;
            end
            P_MONTH:
            begin
                if (acc < 1 || acc > 12)
                begin
                    flag(ST_MONTH, fstart);
                    return;
                end
                mo = acc;
                ph = P_SEP_MD;
            end
            P_DAY:
            begin
                if (acc < 1 || acc > month_length(yr, mo))
                begin
                    flag(ST_DAY, fstart);
                    return;
                end
                dy = acc;
                ph = P_T;
            end
            P_HOUR:
            begin
                if (acc > 23)
                begin
                    flag(ST_HOUR, fstart);
                    return;
                end
                hr = acc;
                ph = P_SEP_HM;
            end
            P_MINUTE:
            begin
                if (acc > 59)
                begin
                    flag(ST_MINUTE, fstart);
                    return;
                end
                mi = acc;
                ph = P_SEP_MS;
            end
            P_SECOND:
            begin
                if (acc == 60)
                begin
                    flag(ST_LEAP, fstart);
                    return;
                end
                if (acc > 60)
                begin
                    flag(ST_SECOND, fstart);
                    return;
                end
                se = acc;
                ph = P_AFTER_SEC;
            end
            P_OFF_HOUR:
            begin
                if (acc > 23)
                begin
                    flag(ST_OFF_RANGE, fstart);
                    return;
                end
                ohr = acc;
                ph = P_OFF_SEP;
            end
            default:
            begin
                if (acc > 59)
                begin
                    flag(ST_OFF_RANGE, fstart);
                    return;
                end
                omi = acc;
                ph = P_DONE;
            end
        endcase
        acc = 0;
        ndig = 0;
    endfunction

    function automatic void start_offset(logic [7:0] b, int unsigned at);
        if (ph == P_FRACTION)
            for (int unsigned k = ndig; k < 9; k++) frac = frac * 10;
        ndig = 0;
        acc = 0;
        if (b == "Z" || b == "z")
            ph = P_DONE;
        else if (b == "+" || b == "-")
        begin
            oneg = (b == "-") ? 1 : 0;
            ph = P_OFF_HOUR;
        end
        else
            flag(ST_OFFSET, at);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int unsigned at;
        bit isd;
        int unsigned d;
        at = idx;
        isd = (b >= "0" && b <= "9");
        d = isd ? 32'(b - "0") : 0;
        case (ph)
            P_YEAR, P_MONTH, P_DAY, P_HOUR, P_MINUTE, P_SECOND, P_OFF_HOUR, P_OFF_MINUTE:
            begin
                if (ndig == 0) fstart = at;
                if (!isd)
                    flag(ST_DIGIT, at);
                else
                begin
                    acc = acc * 10 + d;
                    ndig++;
                    if (ndig >= ((ph == P_YEAR) ? 4 : 2)) close_field();
                end
            end
            P_SEP_YM, P_SEP_MD:
                if (b != "-") flag(ST_SEP, at); else ph = phase_t'(ph + 1);
            P_T:
                if (b != "T" && b != "t") flag(ST_SEP, at); else ph = phase_t'(ph + 1);
            P_SEP_HM, P_SEP_MS, P_OFF_SEP:
                if (b != ":") flag(ST_SEP, at); else ph = phase_t'(ph + 1);
            P_AFTER_SEC:
                if (b == ".")
                begin
                    ph = P_FRACTION;
                    ndig = 0;
                    frac = 0;
                end
                else
                    start_offset(b, at);
            P_FRACTION:
                if (isd)
                begin
                    if (ndig >= 9)
                        flag(ST_FRACTION, at);
                    else
                    begin
                        frac = frac * 10 + d;
                        ndig++;
                    end
                end
                else if (ndig == 0)
                    flag(ST_DIGIT, at);
                else
                    start_offset(b, at);
            default: flag(ST_TRAILING, at);
        endcase
        if (ecode == 0 && idx < 63) idx++;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic lst);
        stamp_t r;
        longint sec, off;
        bit bad;
        if (ecode == 0) parse_byte(b);
        if (!lst) return;
        r = '0;
        if (ecode != 0)
        begin
            r.status = status_t'(ecode[3:0]);
            r.position = 6'(eidx);
        end
        else if (ph != P_DONE)
        begin
            r.status = ST_TRUNC;
            r.position = 6'(idx);
        end
        else
        begin
            sec = epoch_days(yr, mo, dy) * 86400 + longint'(hr) * 3600 + longint'(mi) * 60
                + longint'(se);
            off = longint'(ohr) * 3600 + longint'(omi) * 60;
            sec = (oneg != 0) ? sec + off : sec - off;
            bad = (sec > 64'sd9223372036) || (sec == 64'sd9223372036 && frac > 854775807)
               || (sec < -64'sd9223372037) || (sec == -64'sd9223372037 && frac < 145224192);
            if (bad)
            begin
                r.status = ST_RANGE;
                r.position = 6'd0;
            end
            else
            begin
                r.status = ST_OK;
                r.position = 6'(idx);
                r.instant = sec * 1000000000 + longint'(frac);
            end
        end
        stamp_queue.push_back(r);
        clear_parser();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        fail_count++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back({(i == s.len() - 1), s[i]});
        text_count++;
    endtask

    function automatic string two(int unsigned v);
        return $sformatf("%02d", v);
    endfunction

    function automatic string random_stamp();
        string s;
        int unsigned n;
        s = $sformatf("%04d-%s-%sT%s:%s:%s", $urandom_range(0, 9999),
                      two($urandom_range(1, 12)), two($urandom_range(1, 28)),
                      two($urandom_range(0, 23)), two($urandom_range(0, 59)),
                      two($urandom_range(0, 59)));
        if ($urandom_range(0, 9) == 0)
            s.putc($urandom_range(0, 9), 8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1))
        begin
            n = $urandom_range(1, 9);
            s = {s, "."};
            for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        end
        case ($urandom_range(0, 3))
            0: s = {s, "Z"};
            1: s = {s, "z"};
            default: s = {s, ($urandom_range(0, 1) ? "+" : "-"),
                          two($urandom_range(0, 24)), ":", two($urandom_range(0, 60))};
        endcase
        return s;
    endfunction

    function automatic string damage(string s);
        int unsigned p;
        string t;
        p = $urandom_range(0, s.len() - 1);
        case ($urandom_range(0, 2))
            0: s.putc(p, 8'($urandom_range(0, 255)));
            1: s = s.substr(0, p);
            default:
            begin
                t = "";
                for (int i = 0; i < $urandom_range(1, 4); i++)
                    t = {t, string'(8'($urandom_range(0, 255)))};
                s = {s, t};
            end
        endcase
        return s;
    endfunction

    // Driver: a new beat is offered at the falling edge once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (byte_queue.size() > 0 && !hold_sender
                    && (quiet_stretch || $urandom_range(0, 99) >= 28))
                begin
                    s_tdata <= byte_queue[0][7:0];
                    s_tlast <= byte_queue[0][8];
                    s_tvalid <= 1'b1;
                    byte_queue.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 28);
        end
    end

    // Monitor: predicts on every accepted byte and checks every accepted result.
    always @(posedge clk)
    begin
        stamp_t want;
        stamp_t got;
        cycle_count++;
        in_taken = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (in_taken)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[3:0]);
                got.position = m_tdata[9:4];
                got.instant = m_tdata[73:10];
                result_count++;
                if (stamp_queue.size() == 0)
                    report_mismatch("unexpected result status", got.status, -1);
                else
                begin
                    want = stamp_queue.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.position != want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.instant != want.instant)
                        report_mismatch("instant_ns", got.instant, want.instant);
                end
            end
        end
    end

    initial
    begin
        string s;
        clear_parser();
        push_text("0000-01-01T00:00:00Z");
        push_text("9999-12-31T23:59:59.999999999z");
        push_text("1970-01-01t00:00:00.5+23:59");
        push_text("2000-02-29T12:30:45.123456789-00:00");
        push_text("1900-02-29T00:00:00Z");
        push_text("2023-13-01T00:00:00Z");
        push_text("2023-00-10T00:00:00Z");
        push_text("2023-04-31T00:00:00Z");
        push_text("2023-01-01T24:00:00Z");
        push_text("2023-01-01T00:60:00Z");
        push_text("2023-01-01T00:00:60Z");
        push_text("2023-01-01T00:00:61Z");
        push_text("2023-01-01T00:00:00.1234567890Z");
        push_text("2023-01-01T00:00:00.Z");
        push_text("2023-01-01T00:00:00.");
        push_text("2023-01-01T00:00:00X");
        push_text("2023-01-01T00:00:00+24:00");
        push_text("2023-01-01T00:00:00-05:60");
        push_text("2023-01-01T00:00:00ZZ");
        push_text("2023/01-01T00:00:00Z");
        push_text("20a3-01-01T00:00:00Z");
        push_text("2023-01-01");
        push_text("\xff");
        push_text("0000-01-01T00:00:00+23:59");
        push_text("9999-12-31T23:59:59-23:59");
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (byte_queue.size() < 1950)
        begin
            s = random_stamp();
            if ($urandom_range(0, 3) == 0) s = damage(s);
            push_text(s);
        end
        wait (byte_queue.size() < 1000);
        quiet_stretch = 1;
        wait (byte_queue.size() < 800);
        quiet_stretch = 0;
        hold_sender = 1;
        wait (stamp_queue.size() == 0 && !s_tvalid);
        hold_sender = 0;
        wait (byte_queue.size() == 0 && !s_tvalid);
        wait (stamp_queue.size() == 0);
        repeat (30) @(posedge clk);
        $display("Sent %0d timestamp texts and checked %0d result beats.",
                 text_count, result_count);
        if (fail_count == 0 && stamp_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
